### design/jfr_pkg.sv
package jfr_pkg;

    localparam int PAYLOAD_DEPTH = 8;
    localparam int CNT_W         = $clog2(PAYLOAD_DEPTH + 1);
    localparam int IDX_W         = $clog2(PAYLOAD_DEPTH);

    localparam int NUM_BUTTONS   = 6;
    localparam int BTN_W         = 3;

    localparam logic [7:0] FRAME_START = 8'h02;
    localparam logic [7:0] FRAME_END   = 8'h03;
    localparam logic [7:0] BYTE_MAX    = 8'd127;
    localparam logic [6:0] CHAR_A      = 7'h41;
    localparam logic [6:0] CHAR_L      = 7'h4C;

    localparam int ASCII_ZERO    = 48;
    localparam int STICK_OFFSET  = 200;
    localparam int STICK_LIMIT   = 100;
    localparam int DIGIT_BIAS    = ASCII_ZERO * 111 + STICK_OFFSET;

    localparam logic [15:0] SILENCE_MAX    = 16'hFFFF;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd1000;

    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_MASK    = 1'b1;

    typedef enum logic [1:0] {
        MODE_BYTE     = 2'd0,
        MODE_TICK     = 2'd1,
        MODE_OVERRIDE = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        EV_PRESS   = 2'd0,
        EV_RELEASE = 2'd1,
        EV_STICK   = 2'd2,
        EV_TIMEOUT = 2'd3
    } kind_t;

    typedef struct packed {
        logic              done;
        logic              btn_valid;
        logic [BTN_W-1:0]  btn;
        logic              press;
        logic              stick_valid;
        logic signed [7:0] x;
        logic signed [7:0] y;
    } frame_t;

    typedef struct packed {
        kind_t             kind;
        logic [BTN_W-1:0]  button;
        logic signed [7:0] x;
        logic signed [7:0] y;
        logic [5:0]        states;
    } event_t;

endpackage

### design/joystick_frame_receiver_top.sv
// Joystick frame receiver.
// Input stream (s_axis_*): one transaction per item. tuser carries the mode
// (serial byte, millisecond tick, host button override); tdata carries the
// byte and the override button and press flag.
// Output stream (m_axis_*): zero or one event per input item. tuser carries
// the event kind; tdata carries the button, stick X/Y and latched buttons.
// Configuration: APB port, timeout at address 0, momentary mask at 4.
// Path: an event passes through the input register and then the output
// register; while the output stalls the item waits in the input register.
// Throughput: one item per cycle while the output is not stalled, set by
// the single decode step between the input and output registers; the frame
// and silence state update only when an item passes the decode step.
// Reset: no frame open, buttons and stick zero, silence zero, no timeout
// armed until the first frame ends; timeout 1000 ticks, mask zero.
// Stall: while the output register holds an untaken event the decode step
// holds, and s_axis_tready drops once the input register is full too.
module joystick_frame_receiver_top
    import jfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] data_byte, [10:8] button_index, [11] button_pressed, [15:12] zero
    input  logic [15:0] s_axis_tdata,
    // [1:0] mode
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] event_button, [10:3] joy_x, [18:11] joy_y, [24:19] button_states,
    // [31:25] zero
    output logic [31:0] m_axis_tdata,
    // [1:0] event_kind
    output logic [1:0]  m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic             in_valid_reg;
    logic             in_valid_next;
    mode_t            in_mode_reg;
    logic [7:0]       in_byte_reg;
    logic [BTN_W-1:0] in_index_reg;
    logic             in_pressed_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    event_t           out_reg;
    logic [15:0]      timeout_reg;
    logic [5:0]       mask_reg;

    logic             advance;
    logic             in_take;
    logic             cfg_write;
    frame_t           frame;
    logic             ev_valid;
    event_t           ev;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_TIMEOUT) ? 32'(timeout_reg) : 32'(mask_reg);

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        if (advance)
        begin
            out_valid_next = ev_valid;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    jfr_frame_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_en   (advance && (in_mode_reg == MODE_BYTE)),
        .data_byte (in_byte_reg),
        .frame     (frame)
    );

    jfr_event_unit u_events (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (advance),
        .mode             (in_mode_reg),
        .frame            (frame),
        .override_index   (in_index_reg),
        .override_pressed (in_pressed_reg),
        .timeout_ms       (timeout_reg),
        .momentary_mask   (mask_reg),
        .ev_valid         (ev_valid),
        .ev               (ev)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            timeout_reg   <= TIMEOUT_RESET;
            mask_reg      <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                if (paddr[2] == REG_TIMEOUT)
                begin
                    timeout_reg <= pwdata[15:0];
                end
                else
                begin
                    mask_reg <= pwdata[5:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_mode_reg    <= mode_t'(s_axis_tuser);
            in_byte_reg    <= s_axis_tdata[7:0];
            in_index_reg   <= s_axis_tdata[10:8];
            in_pressed_reg <= s_axis_tdata[11];
        end
        if (advance)
        begin
            out_reg <= ev;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tdata  = {7'd0, out_reg.states, out_reg.y, out_reg.x, out_reg.button};

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while both stages are full");

endmodule

### design/jfr_frame_parser.sv
module jfr_frame_parser
    import jfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_en,
    input  logic [7:0] data_byte,
    output frame_t     frame
);

    logic             in_frame_reg;
    logic             in_frame_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             store_we;
    logic [6:0]       store_reg [PAYLOAD_DEPTH];

    logic [15:0]        sum_x;
    logic [15:0]        sum_y;
    logic signed [15:0] val_x;
    logic signed [15:0] val_y;
    logic [6:0]         letter;
    logic [3:0]         code;

    always_comb
    begin
        sum_x = 16'(store_reg[0]) * 16'd100 + 16'(store_reg[1]) * 16'd10
                + 16'(store_reg[2]);
        sum_y = 16'(store_reg[3]) * 16'd100 + 16'(store_reg[4]) * 16'd10
                + 16'(store_reg[5]);
        val_x = $signed(sum_x) - 16'(DIGIT_BIAS);
        val_y = $signed(sum_y) - 16'(DIGIT_BIAS);
        letter = store_reg[0];
        code = 4'(letter - CHAR_A);
    end

    always_comb
    begin
        in_frame_next = in_frame_reg;
        count_next    = count_reg;
        store_we      = 1'b0;
        frame         = '0;
        frame.btn     = code[3:1];
        frame.press   = ~code[0];
        frame.x       = val_x[7:0];
        frame.y       = val_y[7:0];
        if (byte_en)
        begin
            if (!in_frame_reg)
            begin
                if (data_byte == FRAME_START)
                begin
                    in_frame_next = 1'b1;
                    count_next    = '0;
                end
            end
            else if (data_byte > BYTE_MAX)
            begin
                in_frame_next = 1'b0;
            end
            else if (data_byte == FRAME_END)
            begin
                in_frame_next = 1'b0;
                frame.done    = 1'b1;
                frame.btn_valid = (count_reg == CNT_W'(1)) &&
                                  (letter >= CHAR_A) && (letter <= CHAR_L);
                frame.stick_valid = (count_reg == CNT_W'(6)) &&
                                    (val_x >= -16'(STICK_LIMIT)) &&
                                    (val_x <= 16'(STICK_LIMIT)) &&
                                    (val_y >= -16'(STICK_LIMIT)) &&
                                    (val_y <= 16'(STICK_LIMIT));
            end
            else if (count_reg >= CNT_W'(PAYLOAD_DEPTH))
            begin
                in_frame_next = 1'b0;
            end
            else
            begin
                store_we   = 1'b1;
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[count_reg[IDX_W-1:0]] <= data_byte[6:0];
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(PAYLOAD_DEPTH))
        else $error("payload count beyond depth");

    a_done_leaves_frame: assert property (@(posedge clk) disable iff (!rst_n)
        frame.done |=> !in_frame_reg)
        else $error("frame still open after end byte");

endmodule

### design/jfr_event_unit.sv
module jfr_event_unit
    import jfr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  mode_t            mode,
    input  frame_t           frame,
    input  logic [BTN_W-1:0] override_index,
    input  logic             override_pressed,
    input  logic [15:0]      timeout_ms,
    input  logic [5:0]       momentary_mask,
    output logic             ev_valid,
    output event_t           ev
);

    logic [5:0]        buttons_reg;
    logic [5:0]        buttons_next;
    logic signed [7:0] x_reg;
    logic signed [7:0] x_next;
    logic signed [7:0] y_reg;
    logic signed [7:0] y_next;
    logic [15:0]       silence_reg;
    logic [15:0]       silence_next;
    logic              seen_reg;
    logic              seen_next;

    logic              act;
    logic [BTN_W-1:0]  act_btn;
    logic              act_press;
    logic [5:0]        act_bit;
    logic [15:0]       silence_inc;

    always_comb
    begin
        buttons_next = buttons_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        silence_next = silence_reg;
        seen_next    = seen_reg;
        ev_valid     = 1'b0;
        ev.kind      = EV_STICK;
        act          = 1'b0;
        act_btn      = frame.btn;
        act_press    = frame.press;
        silence_inc  = (silence_reg < SILENCE_MAX) ? silence_reg + 16'd1 : silence_reg;

        case (mode)
            MODE_BYTE:
            begin
                if (frame.done)
                begin
                    silence_next = '0;
                    seen_next    = 1'b0;
                    act          = frame.btn_valid;
                    if (frame.stick_valid)
                    begin
                        x_next   = frame.x;
                        y_next   = frame.y;
                        ev_valid = 1'b1;
                        ev.kind  = EV_STICK;
                    end
                end
            end
            MODE_TICK:
            begin
                silence_next = silence_inc;
                if ((silence_inc > timeout_ms) && !seen_reg)
                begin
                    seen_next = 1'b1;
                    ev_valid  = 1'b1;
                    ev.kind   = EV_TIMEOUT;
                end
            end
            MODE_OVERRIDE:
            begin
                act       = override_index < BTN_W'(NUM_BUTTONS);
                act_btn   = override_index;
                act_press = override_pressed;
            end
            default:
            begin
                act = 1'b0;
            end
        endcase

        act_bit = 6'd1 << act_btn;
        if (act)
        begin
            if (act_press)
            begin
                buttons_next = buttons_reg | (act_bit & ~momentary_mask);
            end
            else
            begin
                buttons_next = buttons_reg & ~act_bit;
            end
            ev_valid = 1'b1;
            ev.kind  = act_press ? EV_PRESS : EV_RELEASE;
        end

        ev.button = act ? act_btn : '0;
        ev.x      = x_next;
        ev.y      = y_next;
        ev.states = buttons_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buttons_reg <= '0;
            x_reg       <= '0;
            y_reg       <= '0;
            silence_reg <= '0;
            seen_reg    <= 1'b1;
        end
        else if (en)
        begin
            buttons_reg <= buttons_next;
            x_reg       <= x_next;
            y_reg       <= y_next;
            silence_reg <= silence_next;
            seen_reg    <= seen_next;
        end
    end

    a_timeout_once: assert property (@(posedge clk) disable iff (!rst_n)
        en && ev_valid && (ev.kind == EV_TIMEOUT) |-> !seen_reg ##1 seen_reg)
        else $error("timeout event without armed state");

    a_frame_clears_silence: assert property (@(posedge clk) disable iff (!rst_n)
        en && (mode == MODE_BYTE) && frame.done |=> (silence_reg == '0) && !seen_reg)
        else $error("silence counter not restarted by frame end");

endmodule
